@@ rtl/collinear_line_counter_rollback_core_macros.svh @@
// Assertion macros shared by the checker of the collinear line counter.
`ifndef COLLINEAR_LINE_COUNTER_ROLLBACK_CORE_MACROS_SVH
`define COLLINEAR_LINE_COUNTER_ROLLBACK_CORE_MACROS_SVH

// Assert a property that is ignored while reset is high.
`define CLRC_ASSERT_DIS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("clrc: assertion failed");

// Assert a property that is checked during reset too.
`define CLRC_ASSERT(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("clrc: assertion failed");

`endif

@@ rtl/clrc_pkg.sv @@
// Package: sizes, codes, table entry types and the bucket hash of the line counter.
`default_nettype none
package clrc_pkg;
   localparam int MAX_POINTS   = 256;
   localparam int PT_AW        = $clog2(MAX_POINTS);
   localparam int PT_CW        = $clog2(MAX_POINTS + 1);
   localparam int LINE_ENTRIES = 32768;
   localparam int LINE_AW      = $clog2(LINE_ENTRIES);
   localparam int LINE_CW      = $clog2(LINE_ENTRIES + 1);
   localparam int TRAIL_DEPTH  = 32768;
   localparam int TRAIL_AW     = $clog2(TRAIL_DEPTH);
   localparam int TRAIL_CW     = $clog2(TRAIL_DEPTH + 1);
   localparam int HASH_BITS    = 12;
   localparam int BUCKETS      = 1 << HASH_BITS;
   localparam int COORD_W      = 9;
   localparam int MAG_W        = 9;
   localparam int MARK_W       = 16;
   localparam int PMARK_W      = 9;
   localparam int VIOL_OUT_W   = 15;
   localparam int VIOL_W       = 16;
   localparam int CNT_W        = 16;
   localparam int KEY_W        = 40;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 15;
   localparam int COUNT_VIOL   = 3;
   localparam int C_OFFSET     = 1 << 19;
   localparam logic signed [9:0] FAMILY_CENTRAL = -10'sd1;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_UNDO = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRUNE_THRESHOLD = 3'd0,
      CSR_MAX_COEFF       = 3'd1,
      CSR_FAMILY_A        = 3'd2,
      CSR_FAMILY_B        = 3'd3,
      CSR_EXCLUDE_CENTRAL = 3'd4,
      CSR_HARD_BOUND      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic               link_null;
      logic [LINE_AW-1:0] link;
      logic [CNT_W-1:0]   count;
   } line_entry_type;

   typedef struct packed {
      logic               empty;
      logic [LINE_AW-1:0] idx;
   } bucket_type;

   typedef struct packed {
      logic [LINE_AW-1:0] idx;
      logic               is_new;
   } trail_entry_type;

   // Fold the key onto the bucket index.
   function automatic logic [HASH_BITS-1:0] hash_of(input logic [KEY_W-1:0] key);
      logic [HASH_BITS-1:0] h;
      h = '0;
      for (int i = 0; i < KEY_W; i++) begin
         h[i % HASH_BITS] = h[i % HASH_BITS] ^ key[i];
      end
      return h;
   endfunction
endpackage
`default_nettype wire

@@ rtl/clrc_req_if.sv @@
// Request channel: add or undo items.
`default_nettype none
interface clrc_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    op;
   logic signed [clrc_pkg::COORD_W-1:0]     x;
   logic signed [clrc_pkg::COORD_W-1:0]     y;
   logic [clrc_pkg::MARK_W-1:0]             trail_mark;
   logic [clrc_pkg::PMARK_W-1:0]            point_mark;
   modport source(output valid, op, x, y, trail_mark, point_mark, input ready);
   modport sink(input valid, op, x, y, trail_mark, point_mark, output ready);
endinterface
`default_nettype wire

@@ rtl/clrc_rsp_if.sv @@
// Response channel: one result per request.
`default_nettype none
interface clrc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               ok;
   logic [clrc_pkg::VIOL_OUT_W-1:0]    violations;
   logic [clrc_pkg::MARK_W-1:0]        trail_length;
   logic [clrc_pkg::PMARK_W-1:0]       point_total;
   logic                               overflow;
   modport source(output valid, ok, violations, trail_length, point_total, overflow,
                  input ready);
   modport sink(input valid, ok, violations, trail_length, point_total, overflow,
                output ready);
endinterface
`default_nettype wire

@@ rtl/collinear_line_counter_rollback_core.sv @@
// Collinear line counter with trail rollback: sequencer, datapath and memories.
//
// The block stores up to 256 points and an exact table of lines through point
// pairs, keyed by the reduced (a,b,c), and counts lines holding three or more
// points. One item is worked at a time; req ready is low while it runs. After
// reset the block clears the bucket heads before it takes the first item (csr
// writes are taken throughout). An add takes each stored point in turn through
// a difference, gcd steps, division of dy and then dx, a multiply and a sum for
// c, and the key; a line that passes the filter then has its bucket chain
// walked and its entry bumped or made. All of it runs on the single shared
// gcd/divide/multiply unit and the one read port of the line memory. An undo,
// or an add that overflows the trail or line table, unwinds the trail entry by
// entry; the result then sits in an output register until the response transfer.
`default_nettype none
module collinear_line_counter_rollback_core (
   input  wire                                  clock,
   input  wire                                  reset,
   clrc_req_if.sink                             req_ch,
   clrc_rsp_if.source                           rsp_ch,
   input  wire                                  csr_we,
   input  wire [clrc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [clrc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   typedef enum logic [17:0] {
      ST_CLEAR    = 18'b000000000000000001,
      ST_IDLE     = 18'b000000000000000010,
      ST_NEXT     = 18'b000000000000000100,
      ST_DIFF     = 18'b000000000000001000,
      ST_GCD      = 18'b000000000000010000,
      ST_DIV      = 18'b000000000000100000,
      ST_MUL      = 18'b000000000001000000,
      ST_CSUM     = 18'b000000000010000000,
      ST_KEY      = 18'b000000000100000000,
      ST_BKT      = 18'b000000001000000000,
      ST_HEAD     = 18'b000000010000000000,
      ST_LINE     = 18'b000000100000000000,
      ST_UPDATE   = 18'b000001000000000000,
      ST_FINISH   = 18'b000010000000000000,
      ST_RB_TEST  = 18'b000100000000000000,
      ST_RB_LINE  = 18'b001000000000000000,
      ST_RB_APPLY = 18'b010000000000000000,
      ST_OUT      = 18'b100000000000000000
   } state_type;

   localparam int PT_W = 2 * clrc_pkg::COORD_W;

   // Configuration registers.
   logic [14:0]       prune_threshold_ff, prune_threshold_in;
   logic [8:0]        max_coeff_ff, max_coeff_in;
   logic signed [9:0] family_a_ff, family_a_in;
   logic [8:0]        family_b_ff, family_b_in;
   logic              exclude_central_ff, exclude_central_in;
   logic [8:0]        hard_bound_ff, hard_bound_in;

   // Control state.
   state_type                          state_ff, state_in;
   logic [clrc_pkg::HASH_BITS-1:0]     clr_ff, clr_in;
   logic [clrc_pkg::VIOL_W-1:0]        viol_ff, viol_in;
   logic [clrc_pkg::TRAIL_CW-1:0]      trail_top_ff, trail_top_in;
   logic [clrc_pkg::PT_CW-1:0]         stored_ff, stored_in;
   logic [clrc_pkg::LINE_CW-1:0]       lines_ff, lines_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // Item and datapath registers.
   logic [clrc_pkg::PT_CW-1:0]           k_ff, k_in;
   logic signed [clrc_pkg::COORD_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [clrc_pkg::MARK_W-1:0]          mark_ff, mark_in;
   logic [clrc_pkg::PMARK_W-1:0]         pmark_ff, pmark_in;
   logic                                 is_undo_ff, is_undo_in;
   logic                                 ovf_ff, ovf_in, prune_ff, prune_in, ok_ff, ok_in;
   logic [clrc_pkg::MAG_W-1:0]           mdx_ff, mdx_in, mdy_ff, mdy_in;
   logic                                 neg_b_ff, neg_b_in;
   logic [clrc_pkg::MAG_W-1:0]           u_ff, u_in, v_ff, v_in, g_ff, g_in;
   logic [3:0]                           sh_ff, sh_in;
   logic [clrc_pkg::MAG_W-1:0]           rem_ff, rem_in, num_ff, num_in;
   logic [3:0]                           dcnt_ff, dcnt_in;
   logic                                 dsel_ff, dsel_in;
   logic [clrc_pkg::MAG_W-1:0]           qa_ff, qa_in, qb_ff, qb_in;
   logic signed [18:0]                   prod_ff, prod_in;
   logic signed [19:0]                   c_ff, c_in;
   logic [clrc_pkg::KEY_W-1:0]           key_ff, key_in;
   logic [clrc_pkg::HASH_BITS-1:0]       hash_ff, hash_in;
   clrc_pkg::bucket_type                 head_ff, head_in;
   logic [clrc_pkg::LINE_AW-1:0]         cur_ff, cur_in;
   logic                                 found_ff, found_in;
   logic [clrc_pkg::CNT_W-1:0]           hit_cnt_ff, hit_cnt_in;
   clrc_pkg::trail_entry_type            rb_ent_ff, rb_ent_in;

   // Response payload registers.
   logic                                 rsp_ok_ff, rsp_ok_in, rsp_ovf_ff, rsp_ovf_in;
   logic [clrc_pkg::VIOL_OUT_W-1:0]      rsp_viol_ff, rsp_viol_in;
   logic [clrc_pkg::MARK_W-1:0]          rsp_tl_ff, rsp_tl_in;
   logic [clrc_pkg::PMARK_W-1:0]         rsp_pt_ff, rsp_pt_in;

   // Memories and their ports.
   logic [PT_W-1:0]                      pt_mem [clrc_pkg::MAX_POINTS];
   clrc_pkg::bucket_type                 bkt_mem [clrc_pkg::BUCKETS];
   clrc_pkg::line_entry_type             line_mem [clrc_pkg::LINE_ENTRIES];
   clrc_pkg::trail_entry_type            trail_mem [clrc_pkg::TRAIL_DEPTH];

   logic [PT_W-1:0]                      pt_q_ff, pt_wd;
   logic                                 pt_we;
   logic [clrc_pkg::PT_AW-1:0]           pt_wa, pt_ra;
   clrc_pkg::bucket_type                 bkt_q_ff, bkt_wd;
   logic                                 bkt_we;
   logic [clrc_pkg::HASH_BITS-1:0]       bkt_wa, bkt_ra;
   clrc_pkg::line_entry_type             line_q_ff, line_wd;
   logic                                 line_we;
   logic [clrc_pkg::LINE_AW-1:0]         line_wa, line_ra;
   clrc_pkg::trail_entry_type            trail_q_ff, trail_wd;
   logic                                 trail_we;
   logic [clrc_pkg::TRAIL_AW-1:0]        trail_wa, trail_ra;

   // Combinational helpers.
   logic signed [9:0]  dx, dy;
   logic [8:0]         g_raw;
   logic [9:0]         trial;
   logic               ge;
   logic signed [10:0] b_s, b_off;
   logic signed [19:0] bxy;
   logic [8:0]         big, lo, hi;
   logic signed [10:0] fa11, fb11, flo, fhi;
   logic               pass;
   logic [clrc_pkg::KEY_W-1:0] key_new;
   logic [clrc_pkg::CNT_W-1:0] cnt_up;
   logic               hard_hit;

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.ok           = rsp_ok_ff;
   assign rsp_ch.violations   = rsp_viol_ff;
   assign rsp_ch.trail_length = rsp_tl_ff;
   assign rsp_ch.point_total  = rsp_pt_ff;
   assign rsp_ch.overflow     = rsp_ovf_ff;

   // Configuration writes.
   always_comb begin
      prune_threshold_in = prune_threshold_ff;
      max_coeff_in       = max_coeff_ff;
      family_a_in        = family_a_ff;
      family_b_in        = family_b_ff;
      exclude_central_in = exclude_central_ff;
      hard_bound_in      = hard_bound_ff;
      if (csr_we) begin
         case (csr_index)
            clrc_pkg::CSR_PRUNE_THRESHOLD: prune_threshold_in = csr_wdata[14:0];
            clrc_pkg::CSR_MAX_COEFF:       max_coeff_in       = csr_wdata[8:0];
            clrc_pkg::CSR_FAMILY_A:        family_a_in        = $signed(csr_wdata[9:0]);
            clrc_pkg::CSR_FAMILY_B:        family_b_in        = csr_wdata[8:0];
            clrc_pkg::CSR_EXCLUDE_CENTRAL: exclude_central_in = csr_wdata[0];
            clrc_pkg::CSR_HARD_BOUND:      hard_bound_in      = csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prune_threshold_ff <= 15'h7FFF;
         max_coeff_ff       <= '0;
         family_a_ff        <= '0;
         family_b_ff        <= '0;
         exclude_central_ff <= 1'b0;
         hard_bound_ff      <= '0;
      end else begin
         prune_threshold_ff <= prune_threshold_in;
         max_coeff_ff       <= max_coeff_in;
         family_a_ff        <= family_a_in;
         family_b_ff        <= family_b_in;
         exclude_central_ff <= exclude_central_in;
         hard_bound_ff      <= hard_bound_in;
      end
   end

   // Datapath terms shared by several states.
   always_comb begin
      dx    = $signed({pt_q_ff[PT_W-1], pt_q_ff[PT_W-1:clrc_pkg::COORD_W]})
              - $signed({x_ff[clrc_pkg::COORD_W-1], x_ff});
      dy    = $signed({pt_q_ff[clrc_pkg::COORD_W-1], pt_q_ff[clrc_pkg::COORD_W-1:0]})
              - $signed({y_ff[clrc_pkg::COORD_W-1], y_ff});
      g_raw = (u_ff | v_ff) << sh_ff;
      trial = {rem_ff, num_ff[clrc_pkg::MAG_W-1]};
      ge    = (trial >= {1'b0, g_ff});
      b_s   = neg_b_ff ? -$signed({2'b00, qb_ff}) : $signed({2'b00, qb_ff});
      bxy   = b_s * y_ff;
      b_off = b_s + 11'sd512;
      big   = (qa_ff > qb_ff) ? qa_ff : qb_ff;
      lo    = (qa_ff < qb_ff) ? qa_ff : qb_ff;
      hi    = (qa_ff < qb_ff) ? qb_ff : qa_ff;
      fa11  = {family_a_ff[9], family_a_ff};
      fb11  = $signed({2'b00, family_b_ff});
      flo   = (fa11 < fb11) ? fa11 : fb11;
      fhi   = (fa11 < fb11) ? fb11 : fa11;
      // Filter priority: coefficient bound, central only, family pair, central exclusion.
      if (max_coeff_ff != '0) begin
         pass = (big <= max_coeff_ff);
      end else if (family_a_ff == clrc_pkg::FAMILY_CENTRAL) begin
         pass = (c_ff == '0);
      end else if ((family_a_ff != '0 || family_b_ff != '0)
                   && ($signed({2'b00, lo}) != flo || $signed({2'b00, hi}) != fhi)) begin
         pass = 1'b0;
      end else begin
         pass = !(exclude_central_ff && c_ff == '0);
      end
      key_new  = {1'b0, qa_ff, b_off[9:0], ~c_ff[19], c_ff[18:0]};
      cnt_up   = hit_cnt_ff + 1'b1;
      hard_hit = (hard_bound_ff != '0) && (big <= hard_bound_ff);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      viol_in      = viol_ff;
      trail_top_in = trail_top_ff;
      stored_in    = stored_ff;
      lines_in     = lines_ff;
      rsp_valid_in = rsp_valid_ff;
      k_in         = k_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      mark_in      = mark_ff;
      pmark_in     = pmark_ff;
      is_undo_in   = is_undo_ff;
      ovf_in       = ovf_ff;
      prune_in     = prune_ff;
      ok_in        = ok_ff;
      mdx_in       = mdx_ff;
      mdy_in       = mdy_ff;
      neg_b_in     = neg_b_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      g_in         = g_ff;
      sh_in        = sh_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      dcnt_in      = dcnt_ff;
      dsel_in      = dsel_ff;
      qa_in        = qa_ff;
      qb_in        = qb_ff;
      prod_in      = prod_ff;
      c_in         = c_ff;
      key_in       = key_ff;
      hash_in      = hash_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      found_in     = found_ff;
      hit_cnt_in   = hit_cnt_ff;
      rb_ent_in    = rb_ent_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_viol_in  = rsp_viol_ff;
      rsp_tl_in    = rsp_tl_ff;
      rsp_pt_in    = rsp_pt_ff;

      pt_we    = 1'b0;
      pt_wa    = stored_ff[clrc_pkg::PT_AW-1:0];
      pt_wd    = {x_ff, y_ff};
      pt_ra    = k_ff[clrc_pkg::PT_AW-1:0];
      bkt_we   = 1'b0;
      bkt_wa   = hash_ff;
      bkt_wd   = '{empty: 1'b1, idx: '0};
      bkt_ra   = hash_ff;
      line_we  = 1'b0;
      line_wa  = cur_ff;
      line_wd  = line_q_ff;
      line_ra  = cur_ff;
      trail_we = 1'b0;
      trail_wa = trail_top_ff[clrc_pkg::TRAIL_AW-1:0];
      trail_wd = '{idx: cur_ff, is_new: 1'b0};
      trail_ra = clrc_pkg::TRAIL_AW'(trail_top_ff - 1'b1);

      // Drop the response once it is taken.
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep the bucket heads to empty.
            bkt_we = 1'b1;
            bkt_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == clrc_pkg::HASH_BITS'(clrc_pkg::BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               x_in     = req_ch.x;
               y_in     = req_ch.y;
               mark_in  = req_ch.trail_mark;
               pmark_in = req_ch.point_mark;
               ovf_in   = 1'b0;
               prune_in = 1'b0;
               k_in     = '0;
               if (req_ch.op == clrc_pkg::OP_UNDO) begin
                  is_undo_in = 1'b1;
                  state_in   = ST_RB_TEST;
               end else if (stored_ff >= clrc_pkg::PT_CW'(clrc_pkg::MAX_POINTS)) begin
                  is_undo_in = 1'b0;
                  ovf_in     = 1'b1;
                  ok_in      = 1'b0;
                  state_in   = ST_OUT;
               end else begin
                  // Remember where this add started on the trail.
                  is_undo_in = 1'b0;
                  mark_in    = clrc_pkg::MARK_W'(trail_top_ff);
                  state_in   = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            if (prune_ff || k_ff == stored_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            mdx_in   = dx[9] ? 9'(-dx) : dx[8:0];
            mdy_in   = dy[9] ? 9'(-dy) : dy[8:0];
            u_in     = dx[9] ? 9'(-dx) : dx[8:0];
            v_in     = dy[9] ? 9'(-dy) : dy[8:0];
            sh_in    = '0;
            neg_b_in = (!dy[9] && dy != '0 && !dx[9] && dx != '0) || (dy[9] && dx[9]);
            state_in = ST_GCD;
         end
         ST_GCD: begin
            // Binary gcd, one step per cycle.
            priority if (u_ff == '0 || v_ff == '0) begin
               g_in     = (g_raw == '0) ? 9'd1 : g_raw;
               rem_in   = '0;
               num_in   = mdy_ff;
               dcnt_in  = '0;
               dsel_in  = 1'b0;
               state_in = ST_DIV;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in  = u_ff >> 1;
               v_in  = v_ff >> 1;
               sh_in = sh_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_in = (u_ff - v_ff) >> 1;
            end else begin
               v_in = (v_ff - u_ff) >> 1;
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle; dy first, then dx.
            rem_in  = ge ? 9'(trial - {1'b0, g_ff}) : trial[8:0];
            num_in  = {num_ff[clrc_pkg::MAG_W-2:0], ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 4'(clrc_pkg::MAG_W - 1)) begin
               if (!dsel_ff) begin
                  qa_in   = {num_ff[clrc_pkg::MAG_W-2:0], ge};
                  rem_in  = '0;
                  num_in  = mdx_ff;
                  dcnt_in = '0;
                  dsel_in = 1'b1;
               end else begin
                  qb_in    = {num_ff[clrc_pkg::MAG_W-2:0], ge};
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = $signed({1'b0, qa_ff}) * x_ff;
            state_in = ST_CSUM;
         end
         ST_CSUM: begin
            c_in     = $signed({prod_ff[18], prod_ff}) + bxy;
            state_in = ST_KEY;
         end
         ST_KEY: begin
            key_in  = key_new;
            hash_in = clrc_pkg::hash_of(key_new);
            if (pass) begin
               state_in = ST_BKT;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_BKT: begin
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            head_in = bkt_q_ff;
            cur_in  = bkt_q_ff.idx;
            line_ra = bkt_q_ff.idx;
            if (bkt_q_ff.empty) begin
               found_in = 1'b0;
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_LINE;
            end
         end
         ST_LINE: begin
            // Walk the chain until the key matches or the chain ends.
            line_ra = line_q_ff.link;
            if (line_q_ff.key == key_ff) begin
               found_in   = 1'b1;
               hit_cnt_in = line_q_ff.count;
               line_ra    = cur_ff;
               state_in   = ST_UPDATE;
            end else if (line_q_ff.link_null) begin
               found_in = 1'b0;
               state_in = ST_UPDATE;
            end else begin
               cur_in = line_q_ff.link;
            end
         end
         ST_UPDATE: begin
            priority if (trail_top_ff >= clrc_pkg::TRAIL_CW'(clrc_pkg::TRAIL_DEPTH)) begin
               ovf_in   = 1'b1;
               state_in = ST_RB_TEST;
            end else if (found_ff) begin
               line_we = 1'b1;
               line_wa = cur_ff;
               line_wd = '{key: key_ff, link_null: line_q_ff.link_null,
                           link: line_q_ff.link, count: cnt_up};
               if (cnt_up == clrc_pkg::CNT_W'(clrc_pkg::COUNT_VIOL)) begin
                  viol_in = viol_ff + 1'b1;
                  if (hard_hit) begin
                     prune_in = 1'b1;
                  end
               end
               trail_we     = 1'b1;
               trail_wd     = '{idx: cur_ff, is_new: 1'b0};
               trail_top_in = trail_top_ff + 1'b1;
               k_in         = k_ff + 1'b1;
               state_in     = ST_NEXT;
            end else if (lines_ff >= clrc_pkg::LINE_CW'(clrc_pkg::LINE_ENTRIES)) begin
               ovf_in   = 1'b1;
               state_in = ST_RB_TEST;
            end else begin
               // Enter a new line at the head of its bucket chain.
               line_we      = 1'b1;
               line_wa      = lines_ff[clrc_pkg::LINE_AW-1:0];
               line_wd      = '{key: key_ff, link_null: head_ff.empty,
                                link: head_ff.idx, count: clrc_pkg::CNT_W'(1)};
               bkt_we       = 1'b1;
               bkt_wa       = hash_ff;
               bkt_wd       = '{empty: 1'b0, idx: lines_ff[clrc_pkg::LINE_AW-1:0]};
               trail_we     = 1'b1;
               trail_wd     = '{idx: lines_ff[clrc_pkg::LINE_AW-1:0], is_new: 1'b1};
               trail_top_in = trail_top_ff + 1'b1;
               lines_in     = lines_ff + 1'b1;
               k_in         = k_ff + 1'b1;
               state_in     = ST_NEXT;
            end
         end
         ST_FINISH: begin
            if (prune_ff) begin
               ok_in = 1'b0;
            end else begin
               pt_we     = 1'b1;
               stored_in = stored_ff + 1'b1;
               ok_in     = (viol_ff < clrc_pkg::VIOL_W'(prune_threshold_ff));
            end
            state_in = ST_OUT;
         end
         ST_RB_TEST: begin
            if (clrc_pkg::MARK_W'(trail_top_ff) > mark_ff) begin
               trail_top_in = trail_top_ff - 1'b1;
               state_in     = ST_RB_LINE;
            end else begin
               if (is_undo_ff) begin
                  stored_in = (pmark_ff > clrc_pkg::PMARK_W'(clrc_pkg::MAX_POINTS))
                              ? clrc_pkg::PT_CW'(clrc_pkg::MAX_POINTS)
                              : clrc_pkg::PT_CW'(pmark_ff);
                  ok_in     = 1'b1;
               end else begin
                  ok_in = 1'b0;
               end
               state_in = ST_OUT;
            end
         end
         ST_RB_LINE: begin
            rb_ent_in = trail_q_ff;
            line_ra   = trail_q_ff.idx;
            state_in  = ST_RB_APPLY;
         end
         ST_RB_APPLY: begin
            if (rb_ent_ff.is_new) begin
               // Unlink the newest line from its bucket.
               bkt_we = 1'b1;
               bkt_wa = clrc_pkg::hash_of(line_q_ff.key);
               bkt_wd = '{empty: line_q_ff.link_null, idx: line_q_ff.link};
               if (lines_ff != '0) begin
                  lines_in = lines_ff - 1'b1;
               end
            end else begin
               if (line_q_ff.count == clrc_pkg::CNT_W'(clrc_pkg::COUNT_VIOL)
                   && viol_ff != '0) begin
                  viol_in = viol_ff - 1'b1;
               end
               if (line_q_ff.count != '0) begin
                  line_we = 1'b1;
                  line_wa = rb_ent_ff.idx;
                  line_wd = '{key: line_q_ff.key, link_null: line_q_ff.link_null,
                              link: line_q_ff.link, count: line_q_ff.count - 1'b1};
               end
            end
            state_in = ST_RB_TEST;
         end
         ST_OUT: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_viol_in  = (viol_ff > clrc_pkg::VIOL_W'(15'h7FFF))
                              ? 15'h7FFF : viol_ff[clrc_pkg::VIOL_OUT_W-1:0];
               rsp_tl_in    = clrc_pkg::MARK_W'(trail_top_ff);
               rsp_pt_in    = clrc_pkg::PMARK_W'(stored_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         viol_ff      <= '0;
         trail_top_ff <= '0;
         stored_ff    <= '0;
         lines_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         viol_ff      <= viol_in;
         trail_top_ff <= trail_top_in;
         stored_ff    <= stored_in;
         lines_ff     <= lines_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      mark_ff    <= mark_in;
      pmark_ff   <= pmark_in;
      is_undo_ff <= is_undo_in;
      ovf_ff     <= ovf_in;
      prune_ff   <= prune_in;
      ok_ff      <= ok_in;
      mdx_ff     <= mdx_in;
      mdy_ff     <= mdy_in;
      neg_b_ff   <= neg_b_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      g_ff       <= g_in;
      sh_ff      <= sh_in;
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      dcnt_ff    <= dcnt_in;
      dsel_ff    <= dsel_in;
      qa_ff      <= qa_in;
      qb_ff      <= qb_in;
      prod_ff    <= prod_in;
      c_ff       <= c_in;
      key_ff     <= key_in;
      hash_ff    <= hash_in;
      head_ff    <= head_in;
      cur_ff     <= cur_in;
      found_ff   <= found_in;
      hit_cnt_ff <= hit_cnt_in;
      rb_ent_ff  <= rb_ent_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_viol_ff <= rsp_viol_in;
      rsp_tl_ff  <= rsp_tl_in;
      rsp_pt_ff  <= rsp_pt_in;
   end

   // Memories: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_wa] <= pt_wd;
      end
      pt_q_ff <= pt_mem[pt_ra];
   end

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[bkt_wa] <= bkt_wd;
      end
      bkt_q_ff <= bkt_mem[bkt_ra];
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_wa] <= line_wd;
      end
      line_q_ff <= line_mem[line_ra];
   end

   always_ff @(posedge clock) begin
      if (trail_we) begin
         trail_mem[trail_wa] <= trail_wd;
      end
      trail_q_ff <= trail_mem[trail_ra];
   end
endmodule
`default_nettype wire

@@ rtl/clrc_checker.sv @@
// Port checker for the collinear line counter and its bind.
`default_nettype none
`include "collinear_line_counter_rollback_core_macros.svh"
module clrc_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_valid,
   input wire                                 req_ready,
   input wire                                 rsp_valid,
   input wire                                 rsp_ready,
   input wire                                 rsp_ok,
   input wire [clrc_pkg::VIOL_OUT_W-1:0]      rsp_violations,
   input wire [clrc_pkg::MARK_W-1:0]          rsp_trail_length,
   input wire [clrc_pkg::PMARK_W-1:0]         rsp_point_total,
   input wire                                 rsp_overflow
);
   // A request keeps the block busy for at least the next cycle.
   `CLRC_ASSERT_DIS(a_busy_after_req, clock, reset, req_valid && req_ready |=> !req_ready)
   // Reset leaves no pending response and starts the bucket sweep.
   `CLRC_ASSERT(a_reset_quiet, clock, reset |=> !req_ready && !rsp_valid)
   // A stalled response holds.
   `CLRC_ASSERT_DIS(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_violations) && $stable(rsp_trail_length) && $stable(rsp_point_total) && $stable(rsp_overflow))
endmodule

bind collinear_line_counter_rollback_core clrc_checker u_clrc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_ok           (rsp_ch.ok),
   .rsp_violations   (rsp_ch.violations),
   .rsp_trail_length (rsp_ch.trail_length),
   .rsp_point_total  (rsp_ch.point_total),
   .rsp_overflow     (rsp_ch.overflow)
);
`default_nettype wire

@@ tb/clrc_tb_types.sv @@
// Item and response record types shared by the line counter testbench.
`timescale 1ns / 1ps
package clrc_tb_types;
   import clrc_pkg::*;

   typedef struct {
      op_type                    op;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [MARK_W-1:0]         trail_mark;
      logic [PMARK_W-1:0]        point_mark;
   } point_item_type;

   typedef struct packed {
      logic                  ok;
      logic [VIOL_OUT_W-1:0] violations;
      logic [MARK_W-1:0]     trail_length;
      logic [PMARK_W-1:0]    point_total;
      logic                  overflow;
   } line_report_type;
endpackage

@@ tb/collinear_line_counter_rollback_core_tb.sv @@
// Self-checking testbench of the collinear line counter with trail rollback.
`timescale 1ns / 1ps
module collinear_line_counter_rollback_core_tb;
   import clrc_pkg::*;
   import clrc_tb_types::*;

   localparam int IDLE_LIMIT = 300000;

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   clrc_req_if req_ch();
   clrc_rsp_if rsp_ch();

   collinear_line_counter_rollback_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Line table shadow: a map from reduced line key to entry, entry counts,
   // and the change trail. Entries are handed out in order and released
   // last-in first-out, exactly as the trail unwinds.
   // ---------------------------------------------------------------------
   int     pt_x [MAX_POINTS];
   int     pt_y [MAX_POINTS];
   longint entry_key [LINE_ENTRIES];
   int     entry_count [LINE_ENTRIES];
   int     trail_entry [TRAIL_DEPTH];
   int     entry_of_key [longint];
   int     viol_count, trail_len, point_count, entries_used, point_high;

   int cfg_threshold, cfg_max_coeff, cfg_family_a, cfg_family_b, cfg_no_central;
   int cfg_hard_bound;

   typedef struct {
      int trail;
      int points;
   } undo_mark_type;

   point_item_type  item_q [$];
   line_report_type report_q [$];
   undo_mark_type   mark_q [$];

   int errors;
   int rsp_seen;
   int idle_cycles;

   function automatic int gcd_of_mags(int p, int q);
      int r;
      while (q != 0) begin
         r = p % q;
         p = q;
         q = r;
      end
      return (p != 0) ? p : 1;
   endfunction

   // Pop trail entries down to the mark, undoing count bumps and new entries.
   function automatic void unwind_trail(int mark);
      int ent;
      int idx;
      while (trail_len > mark) begin
         trail_len--;
         ent = trail_entry[trail_len];
         idx = ent >> 1;
         if (ent & 1) begin
            entry_of_key.delete(entry_key[idx]);
            if (entries_used > 0) entries_used--;
         end else begin
            if (entry_count[idx] == COUNT_VIOL && viol_count > 0) viol_count--;
            if (entry_count[idx] > 0) entry_count[idx]--;
         end
      end
   endfunction

   function automatic bit line_counted(int a, int b, int c);
      int ab, big, lo, hi, flo, fhi;
      ab  = (b < 0) ? -b : b;
      big = (a > ab) ? a : ab;
      if (cfg_max_coeff != 0) return big <= cfg_max_coeff;
      if (cfg_family_a == -1) return c == 0;
      if (cfg_family_a != 0 || cfg_family_b != 0) begin
         lo  = (a < ab) ? a : ab;
         hi  = (a < ab) ? ab : a;
         flo = (cfg_family_a < cfg_family_b) ? cfg_family_a : cfg_family_b;
         fhi = (cfg_family_a < cfg_family_b) ? cfg_family_b : cfg_family_a;
         if (lo != flo || hi != fhi) return 1'b0;
      end
      return !(cfg_no_central != 0 && c == 0);
   endfunction

   // Apply one item to the shadow state and return the report it should give.
   function automatic line_report_type apply_item(point_item_type it);
      line_report_type rep;
      int x, y, dx, dy, g, a, b, c, ab, big, e, start;
      longint key;
      bit ovf, pruned;
      rep.ok = 1'b1;
      ovf    = 1'b0;
      pruned = 1'b0;
      if (it.op == OP_UNDO) begin
         unwind_trail(int'(it.trail_mark));
         point_count = (int'(it.point_mark) > MAX_POINTS) ? MAX_POINTS : int'(it.point_mark);
      end else if (point_count >= MAX_POINTS) begin
         rep.ok = 1'b0;
         ovf    = 1'b1;
      end else begin
         x = it.x;
         y = it.y;
         start = trail_len;
         for (int k = 0; k < point_count && !ovf && !pruned; k++) begin
            dx = pt_x[k] - x;
            dy = pt_y[k] - y;
            g  = gcd_of_mags((dx < 0) ? -dx : dx, (dy < 0) ? -dy : dy);
            a  = dy / g;
            b  = -dx / g;
            if (a < 0 || (a == 0 && b < 0)) begin
               a = -a;
               b = -b;
            end
            c = a * x + b * y;
            if (!line_counted(a, b, c)) continue;
            key = (longint'(a) << 30) | (longint'(b + 512) << 20) | longint'(c + C_OFFSET);
            if (trail_len >= TRAIL_DEPTH) begin
               ovf = 1'b1;
               break;
            end
            if (entry_of_key.exists(key)) begin
               e = entry_of_key[key];
               entry_count[e]++;
               if (entry_count[e] == COUNT_VIOL) begin
                  ab  = (b < 0) ? -b : b;
                  big = (a > ab) ? a : ab;
                  viol_count++;
                  if (cfg_hard_bound != 0 && big <= cfg_hard_bound) pruned = 1'b1;
               end
               trail_entry[trail_len++] = e << 1;
            end else begin
               if (entries_used >= LINE_ENTRIES) begin
                  ovf = 1'b1;
                  break;
               end
               e = entries_used++;
               entry_key[e]       = key;
               entry_count[e]     = 1;
               entry_of_key[key]  = e;
               trail_entry[trail_len++] = (e << 1) | 1;
            end
         end
         if (ovf) begin
            unwind_trail(start);
            rep.ok = 1'b0;
         end else if (pruned) begin
            rep.ok = 1'b0;
         end else begin
            pt_x[point_count] = x;
            pt_y[point_count] = y;
            point_count++;
            if (point_count > point_high) point_high = point_count;
            rep.ok = (viol_count < cfg_threshold);
         end
      end
      rep.violations   = (viol_count > 32767) ? 15'h7fff : viol_count[VIOL_OUT_W-1:0];
      rep.trail_length = trail_len[MARK_W-1:0];
      rep.point_total  = point_count[PMARK_W-1:0];
      rep.overflow     = ovf;
      return rep;
   endfunction

   // Queue an item for the driver together with the report it should give.
   task automatic post_item(op_type op, int x, int y, int tmark, int pmark);
      point_item_type it;
      it.op         = op;
      it.x          = x;
      it.y          = y;
      it.trail_mark = tmark;
      it.point_mark = pmark;
      report_q.push_back(apply_item(it));
      item_q.push_back(it);
      if (op == OP_ADD) mark_q.push_back('{trail_len, point_count});
   endtask

   task automatic write_reg(csr_index_type idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   // Hold until every queued item has gone and every report has come back.
   task automatic drain();
      while (item_q.size() != 0 || report_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(int thr, int mc, int fa, int fb, int nc, int hb);
      write_reg(CSR_PRUNE_THRESHOLD, thr);
      write_reg(CSR_MAX_COEFF, mc);
      write_reg(CSR_FAMILY_A, fa & 10'h3ff);
      write_reg(CSR_FAMILY_B, fb);
      write_reg(CSR_EXCLUDE_CENTRAL, nc);
      write_reg(CSR_HARD_BOUND, hb);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_threshold  = thr;
      cfg_max_coeff  = mc;
      cfg_family_a   = fa;
      cfg_family_b   = fb;
      cfg_no_central = nc;
      cfg_hard_bound = hb;
   endtask

   // Mostly adds in a small window (dense collinearity) with undos back to
   // earlier marks; the rest is full-range points and arbitrary undo marks.
   task automatic random_phase(int n);
      undo_mark_type m;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (point_count >= 14) begin
            m = mark_q[$urandom_range(0, 3)];
            post_item(OP_UNDO, 0, 0, m.trail, m.points);
         end else if (r < 15) begin
            m = mark_q[$urandom_range(0, mark_q.size() - 1)];
            post_item(OP_UNDO, 0, 0, m.trail, m.points);
         end else if (r < 22) begin
            post_item(OP_UNDO, $urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256,
                      $urandom_range(0, 32768), $urandom_range(0, point_high));
         end else if (r < 32) begin
            post_item(OP_ADD, $urandom_range(0, 510) - 255, $urandom_range(0, 510) - 255,
                      $urandom_range(0, 65535), $urandom_range(0, 511));
         end else begin
            post_item(OP_ADD, $urandom_range(0, 10) - 5, $urandom_range(0, 10) - 5,
                      $urandom_range(0, 65535), $urandom_range(0, 511));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: offer queued items in bursts with random gaps between them.
   // ---------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) void'(item_q.pop_front());
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (item_q.size() != 0) begin
               req_ch.valid      <= 1'b1;
               req_ch.op         <= item_q[0].op;
               req_ch.x          <= item_q[0].x;
               req_ch.y          <= item_q[0].y;
               req_ch.trail_mark <= item_q[0].trail_mark;
               req_ch.point_mark <= item_q[0].point_mark;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall in random stretches, and once hold off for a long run
   // while the driver keeps offering, so the block backs up to its input.
   // ---------------------------------------------------------------------
   int  stall_mode_left;
   bit  stall_mode;
   int  long_hold_left;
   bit  long_hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!long_hold_done && rsp_seen == 40) begin
         long_hold_done = 1'b1;
         long_hold_left = 400;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode_left = $urandom_range(16, 96);
            stall_mode      = $urandom_range(0, 1);
         end else begin
            stall_mode_left--;
         end
         rsp_ch.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare every response transfer with the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      line_report_type want;
      line_report_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_seen++;
         got = {rsp_ch.ok, rsp_ch.violations, rsp_ch.trail_length, rsp_ch.point_total,
                rsp_ch.overflow};
         if (report_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected response %p", got);
         end else begin
            want = report_q.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: response %0d: ok %0b/%0b viol %0d/%0d trail %0d/%0d pts %0d/%0d ovf %0b/%0b",
                           rsp_seen, want.ok, got.ok, want.violations, got.violations,
                           want.trail_length, got.trail_length, want.point_total,
                           got.point_total, want.overflow, got.overflow);
            end
         end
      end
   end

   // Watchdog: end the run if no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("collinear_line_counter_rollback_core regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus sequence.
   // ---------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_PRUNE_THRESHOLD;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.op         = OP_ADD;
      req_ch.x          = '0;
      req_ch.y          = '0;
      req_ch.trail_mark = '0;
      req_ch.point_mark = '0;
      rsp_ch.ready      = 1'b0;
      errors = 0;
      rsp_seen = 0;
      idle_cycles = 0;
      viol_count = 0;
      trail_len = 0;
      point_count = 0;
      entries_used = 0;
      point_high = 0;
      cfg_threshold = 32767;
      cfg_max_coeff = 0;
      cfg_family_a = 0;
      cfg_family_b = 0;
      cfg_no_central = 0;
      cfg_hard_bound = 0;
      mark_q.push_back('{0, 0});
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: undo on an empty store, coordinate extremes, a triple on a
      // diagonal, a duplicate point, an undo mark above the trail length and
      // a rollback to a mid-trail mark.
      post_item(OP_UNDO, 0, 0, 0, 0);
      post_item(OP_ADD, -255, -255, 0, 0);
      post_item(OP_ADD, 255, 255, 0, 0);
      post_item(OP_ADD, 0, 0, 0, 0);
      post_item(OP_ADD, 0, 0, 0, 0);
      post_item(OP_ADD, 255, -255, 0, 0);
      post_item(OP_ADD, -255, 255, 0, 0);
      post_item(OP_ADD, 1, 0, 0, 0);
      post_item(OP_ADD, -1, 0, 0, 0);
      post_item(OP_UNDO, 0, 0, 32768, point_count);
      post_item(OP_UNDO, 0, 0, mark_q[3].trail, mark_q[3].points);
      post_item(OP_ADD, 7, -3, 0, 0);
      post_item(OP_UNDO, 0, 0, 0, 0);
      // Sender pauses here until every expected report has come back.
      drain();

      configure(32767, 0, 0, 0, 0, 0);
      random_phase(18);
      drain();
      configure(0, 511, 0, 0, 1, 0);
      random_phase(18);
      drain();
      configure(32767, 0, -1, 0, 1, 0);
      random_phase(18);
      drain();
      configure(3, 0, 1, 0, 1, 0);
      random_phase(18);
      drain();
      configure(32767, 0, 2, 1, 0, 0);
      random_phase(18);
      drain();
      configure(32767, 0, 511, 511, 1, 511);
      random_phase(16);
      drain();
      configure(1, 0, 0, 0, 0, 511);
      random_phase(18);
      drain();
      configure(32767, 2, 0, 0, 0, 1);
      random_phase(18);
      drain();

      // Fill the point store on a grid, add one more to hit the full store,
      // then restore a capacity-saturated mark and unwind everything.
      configure(32767, 1, 0, 0, 0, 0);
      post_item(OP_UNDO, 0, 0, 0, 0);
      for (int i = 0; i < MAX_POINTS; i++) post_item(OP_ADD, (i % 16) - 8, (i / 16) - 8, 0, 0);
      post_item(OP_ADD, 100, 100, 0, 0);
      post_item(OP_UNDO, 0, 0, 32768, MAX_POINTS);
      post_item(OP_ADD, -100, 3, 0, 0);
      post_item(OP_UNDO, 0, 0, 0, 0);
      drain();

      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("collinear_line_counter_rollback_core regression: pass");
      end else begin
         $display("collinear_line_counter_rollback_core regression: fail");
      end
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/clrc_pkg.sv
rtl/clrc_req_if.sv
rtl/clrc_rsp_if.sv
rtl/collinear_line_counter_rollback_core.sv
rtl/clrc_checker.sv
tb/clrc_tb_types.sv
tb/collinear_line_counter_rollback_core_tb.sv
